/* sv/amrp_pkg.sv */
`timescale 1ns / 1ps
package amrp_pkg;

  localparam int NLIT = 26;
  localparam int LIT_MAX = 13;

  localparam logic [5:0] S_INIT = 6'd0, S_BAD = 6'd1, S_DATA = 6'd2, S_SKIPLINE = 6'd3,
    S_END = 6'd4, S_A = 6'd5, S_ALREADY = 6'd6, S_AT = 6'd7, S_ATVER = 6'd8, S_BUSY = 6'd9,
    S_BUSYDOTS = 6'd10, S_DNS = 6'd11, S_ERROR = 6'd12, S_FAIL = 6'd13, S_NUM = 6'd14,
    S_NUMC = 6'd15, S_NUMCC = 6'd16, S_CLOSED = 6'd17, S_CONNECT = 6'd18,
    S_NSENDOK = 6'd19, S_NOIP = 6'd20, S_OK = 6'd21, S_PLUS = 6'd22, S_PLUSC = 6'd23,
    S_CWJAP = 6'd24, S_IPDLINK = 6'd25, S_IPDLEN = 6'd26, S_RECV = 6'd27,
    S_RECVB = 6'd28, S_S = 6'd29, S_SDKVER = 6'd30, S_SEND = 6'd31, S_SENDFAIL = 6'd32,
    S_SENDOK = 6'd33, S_WIFI = 6'd34, S_WCONN = 6'd35, S_WDISC = 6'd36, S_WGOTIP = 6'd37;

  localparam logic [4:0] L_INVER = 5'd0, L_USY = 5'd1, L_OMPILE = 5'd2, L_NSFAIL = 5'd3,
    L_RROR = 5'd4, L_AIL = 5'd5, L_OIP = 5'd6, L_K = 5'd7, L_ECV = 5'd8, L_IFI = 5'd9,
    L_PD = 5'd10, L_READY = 5'd11, L_THINKER = 5'd12, L_VERSION = 5'd13, L_DOTS = 5'd14,
    L_BYTES = 5'd15, L_ND = 5'd16, L_KVERSION = 5'd17, L_ATUS = 5'd18, L_JAP = 5'd19,
    L_ONNECTED = 5'd20, L_ISCONNECT = 5'd21, L_OTIP = 5'd22, L_ENDOK = 5'd23,
    L_OSED = 5'd24, L_NNECT = 5'd25;

  localparam logic [1:0] MODE_BYTE = 2'd0, MODE_LINE_ERR = 2'd1, MODE_OUTGOING = 2'd2;

  localparam logic [4:0] EV_OK = 5'd1, EV_ERROR = 5'd2, EV_FAIL = 5'd3,
    EV_JOIN_TIMEOUT = 5'd4, EV_WRONG_PW = 5'd5, EV_NO_AP = 5'd6, EV_JOIN_FAIL = 5'd7,
    EV_SEND_OK = 5'd8, EV_SEND_FAIL = 5'd9, EV_PROMPT = 5'd10, EV_ALREADY = 5'd11,
    EV_WIFI_UP = 5'd12, EV_WIFI_DOWN = 5'd13, EV_GOT_IP = 5'd14, EV_RECV = 5'd15,
    EV_DNS_FAIL = 5'd16, EV_CLOSED = 5'd17, EV_OPENED = 5'd18, EV_PAYLOAD = 5'd19,
    EV_PARSE_ERR = 5'd20;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] link;
    logic [7:0] data;
    logic       is_local;
  } event_t;

  function automatic logic [3:0] lit_len(input logic [4:0] l);
    case (l)
      L_INVER: lit_len = 4'd10;   L_USY: lit_len = 4'd4;      L_OMPILE: lit_len = 4'd11;
      L_NSFAIL: lit_len = 4'd7;   L_RROR: lit_len = 4'd4;     L_AIL: lit_len = 4'd3;
      L_OIP: lit_len = 4'd4;      L_K: lit_len = 4'd1;        L_ECV: lit_len = 4'd4;
      L_IFI: lit_len = 4'd4;      L_PD: lit_len = 4'd3;       L_READY: lit_len = 4'd13;
      L_THINKER: lit_len = 4'd8;  L_VERSION: lit_len = 4'd8;  L_DOTS: lit_len = 4'd3;
      L_BYTES: lit_len = 4'd5;    L_ND: lit_len = 4'd3;       L_KVERSION: lit_len = 4'd10;
      L_ATUS: lit_len = 4'd5;     L_JAP: lit_len = 4'd4;      L_ONNECTED: lit_len = 4'd8;
      L_ISCONNECT: lit_len = 4'd9; L_OTIP: lit_len = 4'd5;    L_ENDOK: lit_len = 4'd6;
      L_OSED: lit_len = 4'd4;     L_NNECT: lit_len = 4'd5;
      default: lit_len = 4'd0;
    endcase
  endfunction

  function automatic logic [LIT_MAX*8-1:0] lit_str(input logic [4:0] l);
    case (l)
      L_INVER: lit_str = "in version";  L_USY: lit_str = "usy ";
      L_OMPILE: lit_str = "ompile time"; L_NSFAIL: lit_str = "NS Fail";
      L_RROR: lit_str = "RROR";         L_AIL: lit_str = "AIL";
      L_OIP: lit_str = "o ip";          L_K: lit_str = "K";
      L_ECV: lit_str = "ecv ";          L_IFI: lit_str = "IFI ";
      L_PD: lit_str = "PD,";            L_READY: lit_str = "READY CONNECT";
      L_THINKER: lit_str = "-Thinker";  L_VERSION: lit_str = "version:";
      L_DOTS: lit_str = "...";          L_BYTES: lit_str = "bytes";
      L_ND: lit_str = "ND ";            L_KVERSION: lit_str = "K version:";
      L_ATUS: lit_str = "ATUS:";        L_JAP: lit_str = "JAP:";
      L_ONNECTED: lit_str = "ONNECTED"; L_ISCONNECT: lit_str = "ISCONNECT";
      L_OTIP: lit_str = "OT IP";        L_ENDOK: lit_str = "END OK";
      L_OSED: lit_str = "OSED";         L_NNECT: lit_str = "NNECT";
      default: lit_str = '0;
    endcase
  endfunction

  // literal byte at offset, strings are right-aligned
  function automatic logic [7:0] lit_char(input logic [4:0] l, input logic [3:0] off);
    logic [LIT_MAX*8-1:0] s;
    logic [3:0] pos;
    s = lit_str(l);
    pos = lit_len(l) - 4'd1 - off;
    lit_char = s[pos*8 +: 8];
  endfunction

endpackage

/* sv/amrp_out_queue.sv */
`timescale 1ns / 1ps
module amrp_out_queue
  import amrp_pkg::*;
#(
  parameter int Depth = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [Depth-1:0]     load_valid_i,
  input  event_t [Depth-1:0]   load_ev_i,
  input  logic                 load_i,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic                 one_left_o,
  output event_t               head_o
);

  logic [Depth-1:0]   vld_q, vld_d;
  event_t [Depth-1:0] ev_q, ev_d;
  event_t [Depth-1:0] pk;
  logic [Depth-1:0]   pv;

  // compact sparse slots so the head is always slot 0
  always_comb begin
    pk = '0;
    pv = '0;
    for (int i = 0; i < Depth; i++) begin
      if (load_valid_i[i]) begin
        pk = {load_ev_i[i], pk[Depth-1:1]};
        pv = {1'b1, pv[Depth-1:1]};
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (!pv[0]) begin
        pk = {event_t'('0), pk[Depth-1:1]};
        pv = {1'b0, pv[Depth-1:1]};
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    ev_d  = ev_q;
    if (load_i) begin
      vld_d = pv;
      ev_d  = pk;
    end else if (pop_i) begin
      vld_d = {1'b0, vld_q[Depth-1:1]};
      ev_d  = {event_t'('0), ev_q[Depth-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) ev_q <= ev_d;

  assign empty_o    = !vld_q[0];
  assign one_left_o = vld_q[0] && !vld_q[1];
  assign head_o     = ev_q[0];

endmodule

/* sv/at_modem_response_parser.sv */
`timescale 1ns / 1ps
// output: an item's first result is registered and shows in the cycle after it is taken
// throughput: one byte per cycle when it makes at most one result and the output is not
//   stalled; an item with several results holds the input while the result queue drains
// reset: asynchronous active low, parser to line start, flags and versions zero
module at_modem_response_parser
  import amrp_pkg::*;
#(
  parameter int LINK_COUNT  = 5,
  parameter int LENGTH_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // mode[1:0], rx_byte[9:2], link_select[12:10]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // event_kind, link_number, payload_byte, is_local,
                                       // wifi_up, has_address, links_open,
                                       // firmware_version, sdk_version_word
  output logic         m_axis_tlast
);

  localparam int NQ = LINK_COUNT + 1;
  localparam int LW = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;

  logic [1:0] mode;
  logic [7:0] x;
  logic [2:0] sel;
  assign mode = s_axis_tdata[1:0];
  assign x    = s_axis_tdata[9:2];
  assign sel  = s_axis_tdata[12:10];

  logic [5:0]  st_q, st_d;
  logic        xa_q, xa_d;
  logic [4:0]  xl_q, xl_d;
  logic [3:0]  xo_q, xo_d;
  logic [7:0]  num_q, num_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [31:0] atv_q, atv_d, sdk_q, sdk_d;
  logic        up_q, up_d, ip_q, ip_d;
  logic [LINK_COUNT-1:0] con_q, con_d, out_q, out_d;

  // outputs snapshot of status after the step
  logic        up_o_q, ip_o_q;
  logic [4:0]  open_o_q;
  logic [31:0] atv_o_q, sdk_o_q;

  event_t [NQ-1:0] ev;
  logic   [NQ-1:0] evv;
  logic q_empty, q_one, take;
  event_t head;

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= "0") && (c <= "9");
  endfunction

  function automatic event_t mk(input logic [4:0] k);
    mk = '{kind: k, link: 8'd0, data: 8'd0, is_local: 1'b0};
  endfunction

  logic [7:0] dval;
  logic [7:0] acc10;
  logic [LENGTH_BITS-1:0] rem10;
  logic [LW-1:0] nidx;
  logic nin;
  assign dval  = x - "0";
  assign acc10 = 8'((num_q << 3) + (num_q << 1) + dval);
  assign rem10 = LENGTH_BITS'((rem_q << 3) + (rem_q << 1) + {{(LENGTH_BITS-8){1'b0}}, dval});
  assign nidx  = num_q[LW-1:0];
  assign nin   = {24'd0, num_q} < LINK_COUNT;

  always_comb begin
    logic [5:0] nx;
    logic       err;
    st_d = st_q; xa_d = xa_q; xl_d = xl_q; xo_d = xo_q; num_d = num_q; rem_d = rem_q;
    atv_d = atv_q; sdk_d = sdk_q; up_d = up_q; ip_d = ip_q; con_d = con_q; out_d = out_q;
    ev = '0; evv = '0;
    nx = S_BAD; err = 1'b0;
    if (mode == MODE_LINE_ERR) begin
      evv[0] = 1'b1; ev[0] = mk(EV_PARSE_ERR); st_d = S_BAD;
    end else if (mode == MODE_OUTGOING) begin
      if ({29'd0, sel} < LINK_COUNT) out_d[sel[LW-1:0]] = 1'b1;
    end else if (mode == MODE_BYTE && xa_q) begin
      if (xl_q >= 5'(NLIT) || xo_q >= lit_len(xl_q)) xa_d = 1'b0;
      else if (x != lit_char(xl_q, xo_q)) begin
        xa_d = 1'b0;
        if (st_q != S_BAD) begin evv[0] = 1'b1; ev[0] = mk(EV_PARSE_ERR); end
        st_d = S_BAD;
      end else begin
        xo_d = xo_q + 4'd1;
        if (xo_d >= lit_len(xl_q)) xa_d = 1'b0;
      end
    end else if (mode == MODE_BYTE) begin
      unique case (st_q)
        S_BAD: if (x == 8'h0d || x == 8'h0a) nx = S_INIT;
        S_END: nx = (x == 8'h0a) ? S_INIT : S_END;
        S_SKIPLINE: nx = (x == 8'h0a) ? S_END : S_SKIPLINE;
        S_DATA: begin
          evv[0] = 1'b1;
          ev[0] = '{kind: EV_PAYLOAD, link: num_q, data: x, is_local: 1'b0};
          rem_d = rem_q - 1'b1;
          nx = (rem_d == '0) ? S_INIT : S_DATA;
        end
        S_INIT: begin
          if (x == " " || x == 8'h0d || x == 8'h0a || x == 8'hff || x == 8'hfe) nx = S_INIT;
          else if (x == "+") nx = S_PLUS;
          else if (x == ">") begin nx = S_INIT; evv[0] = 1'b1; ev[0] = mk(EV_PROMPT); end
          else if (x == "A") nx = S_A;
          else if (x == "B") begin nx = S_END; xa_d = 1'b1; xl_d = L_INVER; xo_d = '0; end
          else if (x == "b") begin nx = S_BUSY; xa_d = 1'b1; xl_d = L_USY; xo_d = '0; end
          else if (x == "c") begin nx = S_END; xa_d = 1'b1; xl_d = L_OMPILE; xo_d = '0; end
          else if (x == "D") begin nx = S_DNS; xa_d = 1'b1; xl_d = L_NSFAIL; xo_d = '0; end
          else if (x == "E") begin nx = S_ERROR; xa_d = 1'b1; xl_d = L_RROR; xo_d = '0; end
          else if (x == "F") begin nx = S_FAIL; xa_d = 1'b1; xl_d = L_AIL; xo_d = '0; end
          else if (x == "n") begin nx = S_NOIP; xa_d = 1'b1; xl_d = L_OIP; xo_d = '0; end
          else if (x == "O") begin nx = S_OK; xa_d = 1'b1; xl_d = L_K; xo_d = '0; end
          else if (x == "R") begin nx = S_RECV; xa_d = 1'b1; xl_d = L_ECV; xo_d = '0; end
          else if (x == "S") nx = S_S;
          else if (x == "W") begin nx = S_WIFI; xa_d = 1'b1; xl_d = L_IFI; xo_d = '0; end
          else if (is_dig(x)) begin nx = S_NUM; num_d = dval; end
        end
        S_PLUS: begin
          if (x == "I") begin
            nx = S_IPDLINK; xa_d = 1'b1; xl_d = L_PD; xo_d = '0; num_d = '0; rem_d = '0;
          end else if (x == "C") nx = S_PLUSC;
        end
        S_A: begin
          if (x == "T") nx = S_AT;
          else if (x == "L") begin nx = S_ALREADY; xa_d = 1'b1; xl_d = L_READY; xo_d = '0; end
          else if (x == "i") begin
            nx = S_SKIPLINE; xa_d = 1'b1; xl_d = L_THINKER; xo_d = '0;
          end
        end
        S_AT: begin
          nx = S_END;
          if (x == " ") begin
            nx = S_ATVER; xa_d = 1'b1; xl_d = L_VERSION; xo_d = '0; atv_d = '0; num_d = '0;
          end
        end
        S_ATVER, S_SDKVER: begin
          if (is_dig(x)) begin nx = st_q; num_d = acc10; end
          else if (x == "v") nx = st_q;
          else if (x == "." || x == "(" || x == "-" || x == 8'h0d) begin
            nx = (x == ".") ? st_q : S_END;
            if (st_q == S_ATVER) atv_d = {atv_q[23:0], num_q};
            else sdk_d = {sdk_q[23:0], num_q};
            num_d = '0;
          end
        end
        S_ALREADY: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_ALREADY); end
        S_BUSY: if (x == "s" || x == "p") begin
          nx = S_BUSYDOTS; xa_d = 1'b1; xl_d = L_DOTS; xo_d = '0;
        end
        S_BUSYDOTS, S_NSENDOK: if (x == 8'h0d) nx = S_END;
        S_DNS: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_DNS_FAIL); end
        S_ERROR: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_ERROR); end
        S_FAIL: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_FAIL); end
        S_OK: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_OK); end
        S_NOIP, S_WDISC: if (x == 8'h0d) begin
          nx = S_END; ip_d = 1'b0;
          if (st_q == S_WDISC) begin
            up_d = 1'b0; evv[NQ-1] = 1'b1; ev[NQ-1] = mk(EV_WIFI_DOWN);
          end
          for (int i = 0; i < LINK_COUNT; i++) begin
            if (con_q[i]) begin
              evv[i] = 1'b1;
              ev[i] = '{kind: EV_CLOSED, link: 8'(i), data: 8'd0, is_local: !out_q[i]};
            end
          end
          out_d = out_q & ~con_q;
          con_d = '0;
        end
        S_RECV: begin
          if (is_dig(x)) nx = S_RECV;
          else if (x == " ") begin nx = S_RECVB; xa_d = 1'b1; xl_d = L_BYTES; xo_d = '0; end
        end
        S_RECVB: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_RECV); end
        S_S: begin
          if (x == "E") begin nx = S_SEND; xa_d = 1'b1; xl_d = L_ND; xo_d = '0; end
          else if (x == "D") begin
            nx = S_SDKVER; xa_d = 1'b1; xl_d = L_KVERSION; xo_d = '0; sdk_d = '0; num_d = '0;
          end else if (x == "T") begin nx = S_END; xa_d = 1'b1; xl_d = L_ATUS; xo_d = '0; end
        end
        S_SEND: begin
          if (x == "O") begin nx = S_SENDOK; xa_d = 1'b1; xl_d = L_K; xo_d = '0; end
          else if (x == "F") begin nx = S_SENDFAIL; xa_d = 1'b1; xl_d = L_AIL; xo_d = '0; end
        end
        S_SENDOK: if (x == 8'h0d) begin nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_SEND_OK); end
        S_SENDFAIL: if (x == 8'h0d) begin
          nx = S_END; evv[0] = 1'b1; ev[0] = mk(EV_SEND_FAIL);
        end
        S_IPDLINK: begin
          if (is_dig(x)) begin nx = S_IPDLINK; num_d = acc10; end
          else if (x == ",") nx = S_IPDLEN;
        end
        S_IPDLEN: begin
          if (is_dig(x)) begin nx = S_IPDLEN; rem_d = rem10; end
          else if (x == ":") nx = (rem_q == '0) ? S_INIT : S_DATA;
        end
        S_PLUSC: begin
          if (x == "I") nx = S_END;
          else if (x == "W") begin nx = S_CWJAP; xa_d = 1'b1; xl_d = L_JAP; xo_d = '0; end
        end
        S_CWJAP: begin
          evv[0] = 1'b1;
          if (x == "2") ev[0] = mk(EV_WRONG_PW);
          else if (x == "3") ev[0] = mk(EV_NO_AP);
          else if (x == "4") ev[0] = mk(EV_JOIN_FAIL);
          else ev[0] = mk(EV_JOIN_TIMEOUT);
          nx = S_END;
        end
        S_WIFI: begin
          if (x == "C") begin nx = S_WCONN; xa_d = 1'b1; xl_d = L_ONNECTED; xo_d = '0; end
          else if (x == "D") begin
            nx = S_WDISC; xa_d = 1'b1; xl_d = L_ISCONNECT; xo_d = '0;
          end else if (x == "G") begin nx = S_WGOTIP; xa_d = 1'b1; xl_d = L_OTIP; xo_d = '0; end
        end
        S_WCONN: if (x == 8'h0d) begin
          nx = S_END; up_d = 1'b1; evv[0] = 1'b1; ev[0] = mk(EV_WIFI_UP);
        end
        S_WGOTIP: if (x == 8'h0d) begin
          nx = S_END; ip_d = 1'b1; evv[0] = 1'b1; ev[0] = mk(EV_GOT_IP);
        end
        S_NUM: begin
          if (is_dig(x)) begin nx = S_NUM; num_d = acc10; end
          else if (x == ",") nx = S_NUMC;
        end
        S_NUMC: begin
          if (x == "C") nx = S_NUMCC;
          else if (x == "S") begin nx = S_NSENDOK; xa_d = 1'b1; xl_d = L_ENDOK; xo_d = '0; end
        end
        S_NUMCC: begin
          if (x == "L") begin nx = S_CLOSED; xa_d = 1'b1; xl_d = L_OSED; xo_d = '0; end
          else if (x == "O") begin nx = S_CONNECT; xa_d = 1'b1; xl_d = L_NNECT; xo_d = '0; end
        end
        S_CLOSED: if (x == 8'h0d) begin
          nx = S_END;
          if (nin && con_q[nidx]) begin
            evv[0] = 1'b1;
            ev[0] = '{kind: EV_CLOSED, link: num_q, data: 8'd0, is_local: !out_q[nidx]};
            out_d[nidx] = 1'b0; con_d[nidx] = 1'b0;
          end
        end
        S_CONNECT: if (x == 8'h0d) begin
          nx = S_END;
          if (nin) begin
            con_d[nidx] = 1'b1; evv[0] = 1'b1;
            ev[0] = '{kind: EV_OPENED, link: num_q, data: 8'd0, is_local: !out_q[nidx]};
          end
        end
        default: nx = S_BAD;
      endcase
      err = (nx == S_BAD) && (st_q != S_BAD);
      if (err) begin evv[0] = 1'b1; ev[0] = mk(EV_PARSE_ERR); end
      st_d = nx;
    end
  end

  // take a new item when the queue is empty or its last entry leaves now
  assign take = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = q_empty || (q_one && m_axis_tready);

  amrp_out_queue #(.Depth(NQ)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (evv),
    .load_ev_i    (ev),
    .load_i       (take),
    .pop_i        (m_axis_tvalid && m_axis_tready),
    .empty_o      (q_empty),
    .one_left_o   (q_one),
    .head_o       (head)
  );

  logic [4:0] open5;
  always_comb begin
    open5 = '0;
    for (int i = 0; i < LINK_COUNT && i < 5; i++) open5[i] = con_d[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; xa_q <= 1'b0; xl_q <= '0; xo_q <= '0; num_q <= '0; rem_q <= '0;
      atv_q <= '0; sdk_q <= '0; up_q <= 1'b0; ip_q <= 1'b0; con_q <= '0; out_q <= '0;
    end else if (take) begin
      st_q <= st_d; xa_q <= xa_d; xl_q <= xl_d; xo_q <= xo_d; num_q <= num_d;
      rem_q <= rem_d; atv_q <= atv_d; sdk_q <= sdk_d; up_q <= up_d; ip_q <= ip_d;
      con_q <= con_d; out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      up_o_q <= up_d; ip_o_q <= ip_d; open_o_q <= open5; atv_o_q <= atv_d; sdk_o_q <= sdk_d;
    end
  end

  assign m_axis_tvalid = !q_empty;
  assign m_axis_tlast  = q_one;
  assign m_axis_tdata  = {3'b0, sdk_o_q, atv_o_q, open_o_q, ip_o_q, up_o_q,
                          head.is_local, head.data, head.link, head.kind};

endmodule

/* sv/amrp_checker.sv */
`timescale 1ns / 1ps
module amrp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic         m_axis_tlast
);

  // no new transaction while more than one result is pending
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready) else $error("ready while busy");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[4:0] <= 5'd20))
    else $error("bad event kind");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed under stall");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("not ready while empty");

endmodule

bind at_modem_response_parser amrp_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* tb/sv/at_modem_response_parser_test.sv */
`timescale 1ns / 1ps
module at_modem_response_parser_test;
  import amrp_pkg::*;

  localparam int NLINK = 5;
  localparam int ITEM_TARGET = 420;

  typedef struct {
    logic [1:0] mode;
    logic [7:0] rx;
    logic [2:0] sel;
  } rx_item_t;

  typedef struct {
    logic [4:0]  kind;
    logic [7:0]  link;
    logic [7:0]  data;
    logic        loc;
    logic        up;
    logic        ip;
    logic [4:0]  open;
    logic [31:0] fw;
    logic [31:0] sdk;
    logic        last;
  } modem_event_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;
  logic         m_axis_tlast;

  at_modem_response_parser dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  rx_item_t     byte_stream[$];
  modem_event_t pending_events[$];
  int           mismatches = 0;
  int           taken = 0;
  int           pause_point;

  // parser shadow state
  logic [5:0]  pstate = S_INIT;
  logic        lit_on = 1'b0;
  logic [4:0]  lit_id = '0;
  logic [3:0]  lit_pos = '0;
  logic [7:0]  acc = '0;
  logic [15:0] remaining = '0;
  logic [31:0] fw_word = '0;
  logic [31:0] sdk_word = '0;
  logic        sta_up = 1'b0;
  logic        sta_ip = 1'b0;
  logic [NLINK-1:0] conn = '0;
  logic [NLINK-1:0] outg = '0;
  modem_event_t step_events[$];

  function automatic string tail_text(logic [4:0] l);
    case (l)
      L_INVER: return "in version";     L_USY: return "usy ";
      L_OMPILE: return "ompile time";   L_NSFAIL: return "NS Fail";
      L_RROR: return "RROR";            L_AIL: return "AIL";
      L_OIP: return "o ip";             L_K: return "K";
      L_ECV: return "ecv ";             L_IFI: return "IFI ";
      L_PD: return "PD,";               L_READY: return "READY CONNECT";
      L_THINKER: return "-Thinker";     L_VERSION: return "version:";
      L_DOTS: return "...";             L_BYTES: return "bytes";
      L_ND: return "ND ";               L_KVERSION: return "K version:";
      L_ATUS: return "ATUS:";           L_JAP: return "JAP:";
      L_ONNECTED: return "ONNECTED";    L_ISCONNECT: return "ISCONNECT";
      L_OTIP: return "OT IP";           L_ENDOK: return "END OK";
      L_OSED: return "OSED";            L_NNECT: return "NNECT";
      default: return "";
    endcase
  endfunction

  function automatic void note_event(logic [4:0] k, logic [7:0] ln, logic [7:0] d, logic lc);
    modem_event_t e;
    if (step_events.size() >= 6) return;
    e = '{default: '0};
    e.kind = k;
    e.link = ln;
    e.data = d;
    e.loc = lc;
    step_events.push_back(e);
  endfunction

  function automatic void await_tail(logic [4:0] l);
    lit_on = 1'b1;
    lit_id = l;
    lit_pos = '0;
  endfunction

  function automatic bit is_num(logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic void close_link(int i);
    if (i >= NLINK || !conn[i]) return;
    note_event(EV_CLOSED, 8'(i), 8'd0, !outg[i]);
    outg[i] = 1'b0;
    conn[i] = 1'b0;
  endfunction

  function automatic void drop_all_links();
    for (int i = 0; i < NLINK; i++) close_link(i);
  endfunction

  function automatic void parse_byte(logic [7:0] x);
    logic [5:0] nxt;
    string t;
    nxt = S_BAD;
    if (lit_on) begin
      t = tail_text(lit_id);
      if (lit_pos >= t.len()) begin
        lit_on = 1'b0;
        return;
      end
      if (x != t[lit_pos]) begin
        lit_on = 1'b0;
        if (pstate != S_BAD) note_event(EV_PARSE_ERR, 0, 0, 0);
        pstate = S_BAD;
      end else begin
        lit_pos++;
        if (lit_pos >= t.len()) lit_on = 1'b0;
      end
      return;
    end
    case (pstate)
      S_BAD: if (x == "\r" || x == "\n") nxt = S_INIT;
      S_END: nxt = (x == "\n") ? S_INIT : S_END;
      S_SKIPLINE: nxt = (x == "\n") ? S_END : S_SKIPLINE;
      S_DATA: begin
        note_event(EV_PAYLOAD, acc, x, 0);
        remaining = 16'(remaining - 1);
        nxt = (remaining == 0) ? S_INIT : S_DATA;
      end
      S_INIT: begin
        if (x == " " || x == "\r" || x == "\n" || x == 8'hff || x == 8'hfe) nxt = S_INIT;
        else if (x == "+") nxt = S_PLUS;
        else if (x == ">") begin nxt = S_INIT; note_event(EV_PROMPT, 0, 0, 0); end
        else if (x == "A") nxt = S_A;
        else if (x == "B") begin nxt = S_END; await_tail(L_INVER); end
        else if (x == "b") begin nxt = S_BUSY; await_tail(L_USY); end
        else if (x == "c") begin nxt = S_END; await_tail(L_OMPILE); end
        else if (x == "D") begin nxt = S_DNS; await_tail(L_NSFAIL); end
        else if (x == "E") begin nxt = S_ERROR; await_tail(L_RROR); end
        else if (x == "F") begin nxt = S_FAIL; await_tail(L_AIL); end
        else if (x == "n") begin nxt = S_NOIP; await_tail(L_OIP); end
        else if (x == "O") begin nxt = S_OK; await_tail(L_K); end
        else if (x == "R") begin nxt = S_RECV; await_tail(L_ECV); end
        else if (x == "S") nxt = S_S;
        else if (x == "W") begin nxt = S_WIFI; await_tail(L_IFI); end
        else if (is_num(x)) begin nxt = S_NUM; acc = x - "0"; end
      end
      S_PLUS: begin
        if (x == "I") begin
          nxt = S_IPDLINK; await_tail(L_PD); acc = '0; remaining = '0;
        end else if (x == "C") nxt = S_PLUSC;
      end
      S_A: begin
        if (x == "T") nxt = S_AT;
        else if (x == "L") begin nxt = S_ALREADY; await_tail(L_READY); end
        else if (x == "i") begin nxt = S_SKIPLINE; await_tail(L_THINKER); end
      end
      S_AT: begin
        nxt = S_END;
        if (x == " ") begin nxt = S_ATVER; await_tail(L_VERSION); fw_word = '0; acc = '0; end
      end
      S_ATVER, S_SDKVER: begin
        if (is_num(x)) begin nxt = pstate; acc = 8'(acc * 10 + (x - "0")); end
        else if (x == "v") nxt = pstate;
        else if (x == "." || x == "(" || x == "-" || x == "\r") begin
          nxt = (x == ".") ? pstate : S_END;
          if (pstate == S_ATVER) fw_word = {fw_word[23:0], acc};
          else sdk_word = {sdk_word[23:0], acc};
          acc = '0;
        end
      end
      S_ALREADY: if (x == "\r") begin nxt = S_END; note_event(EV_ALREADY, 0, 0, 0); end
      S_BUSY: if (x == "s" || x == "p") begin nxt = S_BUSYDOTS; await_tail(L_DOTS); end
      S_BUSYDOTS, S_NSENDOK: if (x == "\r") nxt = S_END;
      S_DNS: if (x == "\r") begin nxt = S_END; note_event(EV_DNS_FAIL, 0, 0, 0); end
      S_ERROR: if (x == "\r") begin nxt = S_END; note_event(EV_ERROR, 0, 0, 0); end
      S_FAIL: if (x == "\r") begin nxt = S_END; note_event(EV_FAIL, 0, 0, 0); end
      S_NOIP: if (x == "\r") begin nxt = S_END; sta_ip = 1'b0; drop_all_links(); end
      S_OK: if (x == "\r") begin nxt = S_END; note_event(EV_OK, 0, 0, 0); end
      S_RECV: begin
        if (is_num(x)) nxt = S_RECV;
        else if (x == " ") begin nxt = S_RECVB; await_tail(L_BYTES); end
      end
      S_RECVB: if (x == "\r") begin nxt = S_END; note_event(EV_RECV, 0, 0, 0); end
      S_S: begin
        if (x == "E") begin nxt = S_SEND; await_tail(L_ND); end
        else if (x == "D") begin
          nxt = S_SDKVER; await_tail(L_KVERSION); sdk_word = '0; acc = '0;
        end else if (x == "T") begin nxt = S_END; await_tail(L_ATUS); end
      end
      S_SEND: begin
        if (x == "O") begin nxt = S_SENDOK; await_tail(L_K); end
        else if (x == "F") begin nxt = S_SENDFAIL; await_tail(L_AIL); end
      end
      S_SENDOK: if (x == "\r") begin nxt = S_END; note_event(EV_SEND_OK, 0, 0, 0); end
      S_SENDFAIL: if (x == "\r") begin nxt = S_END; note_event(EV_SEND_FAIL, 0, 0, 0); end
      S_IPDLINK: begin
        if (is_num(x)) begin nxt = S_IPDLINK; acc = 8'(acc * 10 + (x - "0")); end
        else if (x == ",") nxt = S_IPDLEN;
      end
      S_IPDLEN: begin
        if (is_num(x)) begin
          nxt = S_IPDLEN;
          remaining = 16'(remaining * 10 + (x - "0"));
        end else if (x == ":") nxt = (remaining == 0) ? S_INIT : S_DATA;
      end
      S_PLUSC: begin
        if (x == "I") nxt = S_END;
        else if (x == "W") begin nxt = S_CWJAP; await_tail(L_JAP); end
      end
      S_CWJAP: begin
        if (x == "2") note_event(EV_WRONG_PW, 0, 0, 0);
        else if (x == "3") note_event(EV_NO_AP, 0, 0, 0);
        else if (x == "4") note_event(EV_JOIN_FAIL, 0, 0, 0);
        else note_event(EV_JOIN_TIMEOUT, 0, 0, 0);
        nxt = S_END;
      end
      S_WIFI: begin
        if (x == "C") begin nxt = S_WCONN; await_tail(L_ONNECTED); end
        else if (x == "D") begin nxt = S_WDISC; await_tail(L_ISCONNECT); end
        else if (x == "G") begin nxt = S_WGOTIP; await_tail(L_OTIP); end
      end
      S_WCONN: if (x == "\r") begin
        nxt = S_END; sta_up = 1'b1; note_event(EV_WIFI_UP, 0, 0, 0);
      end
      S_WDISC: if (x == "\r") begin
        nxt = S_END;
        sta_up = 1'b0;
        sta_ip = 1'b0;
        drop_all_links();
        note_event(EV_WIFI_DOWN, 0, 0, 0);
      end
      S_WGOTIP: if (x == "\r") begin
        nxt = S_END; sta_ip = 1'b1; note_event(EV_GOT_IP, 0, 0, 0);
      end
      S_NUM: begin
        if (is_num(x)) begin nxt = S_NUM; acc = 8'(acc * 10 + (x - "0")); end
        else if (x == ",") nxt = S_NUMC;
      end
      S_NUMC: begin
        if (x == "C") nxt = S_NUMCC;
        else if (x == "S") begin nxt = S_NSENDOK; await_tail(L_ENDOK); end
      end
      S_NUMCC: begin
        if (x == "L") begin nxt = S_CLOSED; await_tail(L_OSED); end
        else if (x == "O") begin nxt = S_CONNECT; await_tail(L_NNECT); end
      end
      S_CLOSED: if (x == "\r") begin nxt = S_END; close_link(acc); end
      S_CONNECT: if (x == "\r") begin
        nxt = S_END;
        if (acc < NLINK) begin
          conn[acc] = 1'b1;
          note_event(EV_OPENED, acc, 0, !outg[acc]);
        end
      end
      default: ;
    endcase
    if (nxt == S_BAD && pstate != S_BAD) note_event(EV_PARSE_ERR, 0, 0, 0);
    pstate = nxt;
  endfunction

  function automatic void predict_events(rx_item_t it);
    step_events.delete();
    if (it.mode == MODE_BYTE) parse_byte(it.rx);
    else if (it.mode == MODE_LINE_ERR) begin
      note_event(EV_PARSE_ERR, 0, 0, 0);
      pstate = S_BAD;
    end else if (it.mode == MODE_OUTGOING) begin
      if (it.sel < NLINK) outg[it.sel] = 1'b1;
    end
    for (int k = 0; k < step_events.size(); k++) begin
      step_events[k].up = sta_up;
      step_events[k].ip = sta_ip;
      step_events[k].open = conn;
      step_events[k].fw = fw_word;
      step_events[k].sdk = sdk_word;
      step_events[k].last = (k == step_events.size() - 1);
      pending_events.push_back(step_events[k]);
    end
  endfunction

  // sender side: prediction runs on each accepted transaction
  always @(posedge clk_i) begin
    rx_item_t it;
    int idle_pct;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.mode = s_axis_tdata[1:0];
        it.rx = s_axis_tdata[9:2];
        it.sel = s_axis_tdata[12:10];
        predict_events(it);
        taken++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        idle_pct = (taken < 140) ? 38 : (taken < 280) ? 49 : 0;
        if (byte_stream.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(taken == pause_point && pending_events.size() != 0)) begin
          it = byte_stream.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, it.sel, it.rx, it.mode};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin
    modem_event_t e;
    modem_event_t g;
    int idle_pct;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        g.kind = m_axis_tdata[4:0];
        g.link = m_axis_tdata[12:5];
        g.data = m_axis_tdata[20:13];
        g.loc = m_axis_tdata[21];
        g.up = m_axis_tdata[22];
        g.ip = m_axis_tdata[23];
        g.open = m_axis_tdata[28:24];
        g.fw = m_axis_tdata[60:29];
        g.sdk = m_axis_tdata[92:61];
        g.last = m_axis_tlast;
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected event kind %0d", g.kind);
        end else begin
          e = pending_events.pop_front();
          if (g.kind !== e.kind || g.link !== e.link || g.data !== e.data ||
              g.loc !== e.loc || g.up !== e.up || g.ip !== e.ip || g.open !== e.open ||
              g.fw !== e.fw || g.sdk !== e.sdk || g.last !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp kind %0d link %0d data %h loc %b up %b ip %b",
                       e.kind, e.link, e.data, e.loc, e.up, e.ip,
                       " open %b fw %h sdk %h last %b",
                       e.open, e.fw, e.sdk, e.last);
              $display("         got kind %0d link %0d data %h loc %b up %b ip %b",
                       g.kind, g.link, g.data, g.loc, g.up, g.ip,
                       " open %b fw %h sdk %h last %b",
                       g.open, g.fw, g.sdk, g.last);
            end
          end
        end
      end
      idle_pct = (taken < 140) ? 49 : (taken < 280) ? 38 : 0;
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic void add_item(logic [1:0] m, logic [7:0] b, logic [2:0] s);
    rx_item_t it;
    it.mode = m;
    it.rx = b;
    it.sel = s;
    byte_stream.push_back(it);
  endfunction

  function automatic void add_text(string s, bit mangle);
    int hit;
    hit = mangle ? $urandom_range(s.len() - 1) : -1;
    for (int i = 0; i < s.len(); i++)
      add_item(MODE_BYTE, (i == hit) ? 8'($urandom) : s[i], 3'($urandom));
  endfunction

  function automatic string pick_line();
    int n;
    string d;
    n = $urandom_range(NLINK);
    case ($urandom_range(23))
      0: return "OK\r\n";
      1: return "ERROR\r\n";
      2: return "FAIL\r\n";
      3: return "SEND OK\r\n";
      4: return "SEND FAIL\r\n";
      5: return "WIFI CONNECTED\r\n";
      6: return "WIFI DISCONNECT\r\n";
      7: return "WIFI GOT IP\r\n";
      8: return "no ip\r\n";
      9: return $sformatf("+CWJAP:%0d\r\n", $urandom_range(1, 5));
      10, 11: return $sformatf("%0d,CONNECT\r\n", n);
      12: return $sformatf("%0d,CLOSED\r\n", n);
      13: return "DNS Fail\r\n";
      14: return ">";
      15: return "ALREADY CONNECT\r\n";
      16: return $sformatf("Recv %0d bytes\r\n", $urandom_range(200));
      17: return $sformatf("AT version:%0d.%0d.%0d.0(x)\r\n", $urandom_range(255),
                           $urandom_range(9), $urandom_range(300));
      18: return $sformatf("SDK version:v%0d.%0d-dev\r\n", $urandom_range(9),
                           $urandom_range(255));
      19: return ($urandom_range(1)) ? "busy s...\r\n" : "busy p...\r\n";
      20: begin
        d = "";
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) d = {d, string'(8'($urandom))};
        return $sformatf("+IPD,%0d,%0d:%s", $urandom_range(NLINK), n, d);
      end
      21: return "Ai-Thinker Technology\r\n";
      22: return $sformatf("%0d,SEND OK\r\nSTATUS:2\r\n+CIFSR:x\r\n", n);
      default: return "Bin version x\r\ncompile time x\r\n";
    endcase
  endfunction

  initial begin
    // directed: prompt, extremes, all modes, wraps, empty payload, burst close
    add_item(MODE_BYTE, ">", 3'd0);
    add_item(MODE_BYTE, 8'hff, 3'd7);
    add_item(MODE_BYTE, 8'hfe, 3'd0);
    add_item(MODE_OUTGOING, 8'h00, 3'd7);
    add_item(MODE_OUTGOING, 8'hff, 3'd1);
    add_item(2'd3, 8'hff, 3'd7);
    add_item(MODE_LINE_ERR, 8'h00, 3'd0);
    add_item(MODE_BYTE, "\n", 3'd0);
    for (int i = 0; i < NLINK; i++) add_text($sformatf("%0d,CONNECT\r\n", i), 0);
    add_text("+IPD,300,65537:z", 0);
    add_text("+IPD,1,0:", 0);
    add_text("9,CLOSED\r\n", 0);
    add_text("WIFI DISCONNECT\r\n", 0);
    add_text("Ex", 0);
    add_text("\r\n", 0);
    pause_point = byte_stream.size() + 40;
    while (byte_stream.size() < ITEM_TARGET) begin
      case ($urandom_range(19))
        0: add_item(MODE_LINE_ERR, 8'($urandom), 3'($urandom));
        1: add_item(MODE_OUTGOING, 8'($urandom), 3'($urandom_range(7)));
        2: add_item(2'd3, 8'($urandom), 3'($urandom));
        3: add_item(MODE_BYTE, 8'($urandom), 3'($urandom));
        4, 5: add_text(pick_line(), 1);
        default: add_text(pick_line(), 0);
      endcase
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (byte_stream.size() != 0 || s_axis_tvalid || pending_events.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
